>>> rtl/hptc_pkg.sv
package hptc_pkg;

    localparam int NUM_W  = 56;
    localparam int DEN_W  = 24;
    localparam int PROD_W = 80;
    localparam int TERM_W = 66;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FF     = 3'd4;

    localparam logic REQ_BEGIN  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [DEN_W-1:0] I_DIVISOR = 24'd2000000;
    localparam int D_SCALE = 15625;
    localparam int D_SHIFT = 21;
    localparam int I_SHIFT = 15;
    localparam int P_SHIFT = 16;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } hptc_op_t;

    typedef struct packed {
        logic     start;
        hptc_op_t op;
    } hptc_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_nz;
    } hptc_sts_t;

endpackage

>>> rtl/hptc_serial_unit.sv
module hptc_serial_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hptc_pkg::hptc_cmd_t           cmd,
    input  logic [hptc_pkg::NUM_W-1:0]    op_a,
    input  logic [hptc_pkg::DEN_W-1:0]    op_b,
    output hptc_pkg::hptc_sts_t           sts,
    output logic [hptc_pkg::PROD_W-1:0]   prod,
    output logic [hptc_pkg::NUM_W-1:0]    quot
);

    localparam int NW = hptc_pkg::NUM_W;
    localparam int DW = hptc_pkg::DEN_W;
    localparam int PW = hptc_pkg::PROD_W;
    localparam int CW = hptc_pkg::CNT_W;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    hptc_pkg::hptc_op_t  op_reg, op_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [PW-1:0]       mcand_reg, mcand_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]       b_reg, b_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [NW-1:0]       quot_reg, quot_next;
    logic [DW:0]         trial;
    logic [DW:0]         trial_sub;
    logic                trial_ge;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        trial      = {rem_reg, quot_reg[NW-1]};
        trial_sub  = trial - {1'b0, b_reg};
        trial_ge   = (trial >= {1'b0, b_reg});
        if (cmd.start) begin
            busy_next  = 1'b1;
            op_next    = cmd.op;
            cnt_next   = CW'(NW - 1);
            mcand_next = PW'(op_a);
            acc_next   = '0;
            b_next     = op_b;
            rem_next   = '0;
            quot_next  = op_a;
        end else if (busy_reg) begin
            unique case (op_reg)
                hptc_pkg::OP_MUL: begin
                    if (b_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        if (b_reg[0]) acc_next = acc_reg + mcand_reg;
                        mcand_next = {mcand_reg[PW-2:0], 1'b0};
                        b_next     = {1'b0, b_reg[DW-1:1]};
                    end
                end
                hptc_pkg::OP_DIV: begin
                    rem_next  = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
                    quot_next = {quot_reg[NW-2:0], trial_ge};
                    if (cnt_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= hptc_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign sts  = '{busy: busy_reg, done: done_reg, rem_nz: |rem_reg};
    assign prod = acc_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/heading_pid_turn_controller_top.sv
// channel  | dir | ports                  | word
// input    | in  | s_tvalid/s_tready      | s_tdata: heading[15:0], interval_us[31:16];
//          |     |                        | s_tuser: req_type
// result   | out | m_tvalid/m_tready      | m_tdata: left_power[15:0], right_power[31:16],
//          |     |                        | turn_done[32], zero fill above
// config   | in  | cfg_wr_en              | cfg_addr index, cfg_wr_data value
//
// Begin word: goes straight to the result stage. Update word: wrap steps, 3 divides
// (the first skipped when the begin offset is zero) and 4 multiplies on the shared
// bit-serial multiply/divide unit. One word in flight; s_tready high only when idle.
// Result held in the output register until taken. aresetn synchronous, active low.
module heading_pid_turn_controller_top #(
    parameter int HEADING_FRAC_BITS = 7,
    parameter int GAIN_FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // heading[15:0], interval_us[31:16]
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // left_power[15:0], right_power[31:16], turn_done[32]
    input  logic        cfg_wr_en,
    input  logic [hptc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [23:0] cfg_wr_data
);

    localparam int NW      = hptc_pkg::NUM_W;
    localparam int DW      = hptc_pkg::DEN_W;
    localparam int PW      = hptc_pkg::PROD_W;
    localparam int TW      = hptc_pkg::TERM_W;
    localparam int FULL    = 360 << HEADING_FRAC_BITS;
    localparam int HALF    = 180 << HEADING_FRAC_BITS;
    localparam int EW      = $clog2(FULL) + 2;
    localparam int DONE_LIM = 2 << HEADING_FRAC_BITS;
    localparam int P_SH    = GAIN_FRAC_BITS + 1;
    localparam int ID_SH   = GAIN_FRAC_BITS + HEADING_FRAC_BITS;
    localparam logic signed [EW-1:0] FULL_C = EW'(FULL);
    localparam logic signed [EW-1:0] HALF_C = EW'(HALF);
    localparam logic signed [15:0]   LIM_C  = 16'(DONE_LIM);
    localparam logic [PW-1:0]        PROD_LIM = PW'(1) << 62;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRAP, ST_PDIV, ST_PMUL, ST_IMUL, ST_IDIV,
        ST_IMUL2, ST_DDIV, ST_DMUL, ST_SUM, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic               go_reg, go_next;
    logic signed [15:0] target_reg, target_next;
    logic [23:0]        kp_reg, kp_next;
    logic [23:0]        ki_reg, ki_next;
    logic [23:0]        kd_reg, kd_next;
    logic [14:0]        ff_reg, ff_next;
    logic signed [16:0] sd_reg, sd_next;
    logic signed [15:0] prev_reg, prev_next;
    logic signed [39:0] iacc_reg, iacc_next;
    logic               done_reg, done_next;
    logic signed [EW-1:0] werr_reg, werr_next;
    logic signed [15:0] e_reg, e_next;
    logic [15:0]        dt_reg, dt_next;
    logic [NW-1:0]      mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic signed [TW-1:0] sum_reg, sum_next;
    logic [32:0]        res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    hptc_pkg::hptc_cmd_t cmd;
    hptc_pkg::hptc_sts_t sts;
    logic [NW-1:0]      op_a;
    logic [DW-1:0]      op_b;
    logic [PW-1:0]      prod;
    logic [NW-1:0]      quot;

    logic               in_acc;
    logic signed [15:0] in_head;
    logic [15:0]        e_abs;
    logic [16:0]        sd_abs;
    logic signed [16:0] s_sum;
    logic [16:0]        s_abs;
    logic signed [16:0] d_diff;
    logic [16:0]        d_abs;
    logic [39:0]        iacc_abs;
    logic [30:0]        dmul;
    logic signed [41:0] m42;
    logic signed [41:0] iacc_sum;
    logic [PW-1:0]      d_mag;
    logic signed [66:0] pw67;
    logic signed [66:0] ff67;
    logic signed [66:0] left67;
    logic signed [66:0] right67;
    logic signed [15:0] e_wrapped;

    function automatic logic signed [TW-1:0] scale_term(input logic [PW-1:0] m,
                                                        input logic neg, input int sh);
        logic signed [PW:0] v;
        begin
            v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
            v = v >>> sh;
            return $signed(v[TW-1:0]);
        end
    endfunction

    function automatic logic [15:0] sat16(input logic signed [66:0] v);
        begin
            if (v > 67'sd32767) return 16'h7fff;
            else if (v < -67'sd32768) return 16'h8000;
            else return v[15:0];
        end
    endfunction

    hptc_serial_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op_a    (op_a),
        .op_b    (op_b),
        .sts     (sts),
        .prod    (prod),
        .quot    (quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_head  = $signed(s_tdata[15:0]);

    always_comb begin
        e_abs    = e_reg[15] ? 16'(-e_reg) : 16'(e_reg);
        sd_abs   = sd_reg[16] ? 17'(-sd_reg) : 17'(sd_reg);
        s_sum    = {e_reg[15], e_reg} + {prev_reg[15], prev_reg};
        s_abs    = s_sum[16] ? 17'(-s_sum) : 17'(s_sum);
        d_diff   = {e_reg[15], e_reg} - {prev_reg[15], prev_reg};
        d_abs    = d_diff[16] ? 17'(-d_diff) : 17'(d_diff);
        iacc_abs = iacc_reg[39] ? 40'(-iacc_reg) : 40'(iacc_reg);
        dmul     = 31'(d_abs) * 31'(hptc_pkg::D_SCALE);
        m42      = $signed({9'd0, prod[32:0]});
        iacc_sum = {{2{iacc_reg[39]}}, iacc_reg} + (s_sum[16] ? -m42 : m42);
        d_mag    = (prod > PROD_LIM) ? PROD_LIM : prod;
        pw67     = 67'(sum_reg);
        ff67     = $signed({52'd0, ff_reg});
        left67   = (sum_reg > 0) ? (pw67 + ff67) : (pw67 - ff67);
        right67  = (sum_reg > 0) ? (-pw67 - ff67) : (-pw67 + ff67);
        if (werr_reg > EW'(32767)) e_wrapped = 16'sh7fff;
        else if (werr_reg < -EW'(32768)) e_wrapped = -16'sh8000;
        else e_wrapped = werr_reg[15:0];
    end

    always_comb begin
        state_next    = state_reg;
        go_next       = go_reg;
        target_next   = target_reg;
        kp_next       = kp_reg;
        ki_next       = ki_reg;
        kd_next       = kd_reg;
        ff_next       = ff_reg;
        sd_next       = sd_reg;
        prev_next     = prev_reg;
        iacc_next     = iacc_reg;
        done_next     = done_reg;
        werr_next     = werr_reg;
        e_next        = e_reg;
        dt_next       = dt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sum_next      = sum_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        cmd           = '{start: 1'b0, op: hptc_pkg::OP_MUL};
        op_a          = '0;
        op_b          = '0;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                hptc_pkg::CFG_TARGET: target_next = $signed(cfg_wr_data[15:0]);
                hptc_pkg::CFG_KP:     kp_next = cfg_wr_data;
                hptc_pkg::CFG_KI:     ki_next = cfg_wr_data;
                hptc_pkg::CFG_KD:     kd_next = cfg_wr_data;
                hptc_pkg::CFG_FF:     ff_next = cfg_wr_data[14:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser[0] == hptc_pkg::REQ_BEGIN) begin
                        sd_next    = {in_head[15], in_head} - {target_reg[15], target_reg};
                        prev_next  = '0;
                        iacc_next  = '0;
                        done_next  = 1'b0;
                        res_next   = '0;
                        state_next = ST_FIN;
                    end else begin
                        werr_next  = EW'(target_reg) - EW'(in_head);
                        dt_next    = s_tdata[31:16];
                        sum_next   = '0;
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                if (werr_reg >= HALF_C) begin
                    werr_next = werr_reg - FULL_C;
                end else if (werr_reg < -HALF_C) begin
                    werr_next = werr_reg + FULL_C;
                end else begin
                    e_next     = e_wrapped;
                    go_next    = 1'b1;
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                op_a = NW'(e_abs) << hptc_pkg::P_SHIFT;
                op_b = DW'(sd_abs);
                if (go_reg) begin
                    if (sd_reg == '0) begin
                        mag_next   = (e_reg > 0) ? NW'(32'h7fff_ffff)
                                   : ((e_reg < 0) ? NW'(32'h8000_0000) : '0);
                        neg_next   = e_reg[15];
                        state_next = ST_PMUL;
                    end else begin
                        cmd     = '{start: 1'b1, op: hptc_pkg::OP_DIV};
                        go_next = 1'b0;
                    end
                end else if (sts.done) begin
                    mag_next   = quot;
                    neg_next   = e_reg[15] ^ sd_reg[16];
                    go_next    = 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: begin
                op_a = mag_reg;
                op_b = kp_reg;
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_MUL};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    sum_next   = sum_reg + scale_term(prod, neg_reg, P_SH);
                    go_next    = 1'b1;
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: begin
                op_a = NW'(s_abs);
                op_b = DW'(dt_reg);
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_MUL};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    if (iacc_sum > 42'sh7f_ffff_ffff) iacc_next = 40'sh7f_ffff_ffff;
                    else if (iacc_sum < -42'sh80_0000_0000) iacc_next = 40'sh80_0000_0000;
                    else iacc_next = iacc_sum[39:0];
                    go_next    = 1'b1;
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV: begin
                op_a = NW'(iacc_abs) << hptc_pkg::I_SHIFT;
                op_b = hptc_pkg::I_DIVISOR;
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_DIV};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    mag_next   = quot + NW'(iacc_reg[39] && sts.rem_nz);
                    neg_next   = iacc_reg[39];
                    go_next    = 1'b1;
                    state_next = ST_IMUL2;
                end
            end
            ST_IMUL2: begin
                op_a = mag_reg;
                op_b = ki_reg;
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_MUL};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    sum_next   = sum_reg + scale_term(prod, neg_reg, ID_SH);
                    go_next    = 1'b1;
                    state_next = ST_DDIV;
                end
            end
            ST_DDIV: begin
                op_a = NW'(dmul) << hptc_pkg::D_SHIFT;
                op_b = (dt_reg == '0) ? DW'(1) : DW'(dt_reg);
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_DIV};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    mag_next   = quot + NW'(d_diff[16] && sts.rem_nz);
                    neg_next   = d_diff[16];
                    go_next    = 1'b1;
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: begin
                op_a = mag_reg;
                op_b = kd_reg;
                if (go_reg) begin
                    cmd     = '{start: 1'b1, op: hptc_pkg::OP_MUL};
                    go_next = 1'b0;
                end else if (sts.done) begin
                    sum_next   = sum_reg + scale_term(d_mag, neg_reg, ID_SH);
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                prev_next = e_reg;
                if (e_reg < LIM_C && e_reg > -LIM_C) done_next = 1'b1;
                res_next   = {done_reg || (e_reg < LIM_C && e_reg > -LIM_C),
                              sat16(right67), sat16(left67)};
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {7'd0, res_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            target_reg   <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            ff_reg       <= '0;
            sd_reg       <= '0;
            prev_reg     <= '0;
            iacc_reg     <= '0;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            target_reg   <= target_next;
            kp_reg       <= kp_next;
            ki_reg       <= ki_next;
            kd_reg       <= kd_next;
            ff_reg       <= ff_next;
            sd_reg       <= sd_next;
            prev_reg     <= prev_next;
            iacc_reg     <= iacc_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        werr_reg    <= werr_next;
        e_reg       <= e_next;
        dt_reg      <= dt_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        sum_reg     <= sum_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/hptc_checker.sv
module hptc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // held result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a word in flight");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("fill bits of result word not zero");

endmodule

bind heading_pid_turn_controller_top hptc_checker u_hptc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
